/* rtl/core/tpc_pkg.sv */
// Shared types, widths, latencies and codes of the triangle containment pipeline.
package tpc_pkg;

    localparam int CW     = 32;          // Q16.16 coordinate width
    localparam int DW     = CW + 1;      // vertex difference width
    localparam int PW     = 2 * DW;      // product of two differences
    localparam int NW     = PW + 1;      // plane normal / edge test width
    localparam int SPLIT  = DW;          // low part of a split wide operand
    localparam int XW     = NW + SPLIT;  // numerator and edge normal width
    localparam int QB     = 35;          // height quotient bits
    localparam int NB     = 30;          // normalized component bits
    localparam int RW     = NB + 1;      // root width
    localparam int NFB    = 14;          // edge normal fraction bits
    localparam int ENW    = 16;          // edge normal output width

    localparam int FRONT_LAT = 6;
    localparam int HGT_LAT   = QB + 4;
    localparam int NRM_LAT   = 6 + 32 + (NFB + 1) + 1;
    localparam int HDLY      = NRM_LAT - HGT_LAT;
    localparam int TOTAL_LAT = FRONT_LAT + NRM_LAT;

    localparam logic [1:0] EDGE0 = 2'd0;
    localparam logic [1:0] EDGE1 = 2'd1;
    localparam logic [1:0] EDGE2 = 2'd2;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [NW-1:0] t_nrm;
    typedef logic signed [XW-1:0] t_wide;
    typedef logic signed [ENW-1:0] t_en;

    typedef struct packed {
        logic       in_tri;
        logic [1:0] failed;
        logic       degen;
        logic       want;
    } t_side;

    function automatic t_diff f_sub(input t_coord a, input t_coord b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

endpackage

/* rtl/core/triangle_point_containment_test_unit.sv */
// Top level of the triangle point containment and plane height pipeline.
//
// Usage:
//   Drive a triangle (three Q16.16 vertices) and a query point (x, z) and pulse
//   start. busy is held low: a new word is taken at every clock edge at which
//   start is high, so one word per cycle is sustained.
//   Each word produces exactly one result word, shown for a single cycle with
//   o_valid high: inside flag, first failing edge, plane height (saturated),
//   unit edge normal of the failing edge in Q1.14, and the degenerate flag.
//   From the accepting edge to the result, each word passes 6 front stages
//   (differences, normal, edge tests, cross products) followed by the
//   54-stage edge-normal path, which is set by the 32-stage square root
//   and 15-stage dividers. The 39-stage height divider runs alongside and
//   is delayed to match.
//   Results leave in input order. The receiver cannot stall; nothing waits.
//   Synchronous active-low reset drops every word in flight; no result appears
//   until a new word is accepted after reset.
module triangle_point_containment_test_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tpc_pkg::t_coord i_v0_x,
    input  tpc_pkg::t_coord i_v0_y,
    input  tpc_pkg::t_coord i_v0_z,
    input  tpc_pkg::t_coord i_v1_x,
    input  tpc_pkg::t_coord i_v1_y,
    input  tpc_pkg::t_coord i_v1_z,
    input  tpc_pkg::t_coord i_v2_x,
    input  tpc_pkg::t_coord i_v2_y,
    input  tpc_pkg::t_coord i_v2_z,
    input  tpc_pkg::t_coord i_query_x,
    input  tpc_pkg::t_coord i_query_z,
    output logic            o_valid,
    output logic            o_inside_res,
    output logic [1:0]      o_failed_edge,
    output tpc_pkg::t_coord o_height,
    output tpc_pkg::t_en    o_edge_norm_x,
    output tpc_pkg::t_en    o_edge_norm_y,
    output tpc_pkg::t_en    o_edge_norm_z,
    output logic            o_degenerate
);
    import tpc_pkg::*;

    t_coord w_vx [3], w_vy [3], w_vz [3];
    logic   w_fvalid;
    t_side  w_fside;
    t_wide  w_num;
    t_nrm   w_ny;
    t_coord w_v0y;
    t_wide  w_c [3];
    t_coord w_height;
    logic   w_nvalid;
    t_side  w_nside;
    t_en    w_en [3];
    t_coord r_hdly [HDLY];

    // never stalls: a word can enter every cycle
    assign busy = 1'b0;

    assign w_vx[0] = i_v0_x;
    assign w_vx[1] = i_v1_x;
    assign w_vx[2] = i_v2_x;
    assign w_vy[0] = i_v0_y;
    assign w_vy[1] = i_v1_y;
    assign w_vy[2] = i_v2_y;
    assign w_vz[0] = i_v0_z;
    assign w_vz[1] = i_v1_z;
    assign w_vz[2] = i_v2_z;

    tpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_vx    (w_vx),
        .i_vy    (w_vy),
        .i_vz    (w_vz),
        .i_qx    (i_query_x),
        .i_qz    (i_query_z),
        .o_valid (w_fvalid),
        .o_side  (w_fside),
        .o_num   (w_num),
        .o_ny    (w_ny),
        .o_v0y   (w_v0y),
        .o_c     (w_c)
    );

    tpc_height u_height (
        .i_clk    (i_clk),
        .i_num    (w_num),
        .i_ny     (w_ny),
        .i_v0y    (w_v0y),
        .i_degen  (w_fside.degen),
        .o_height (w_height)
    );

    tpc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fvalid),
        .i_side  (w_fside),
        .i_c     (w_c),
        .o_valid (w_nvalid),
        .o_side  (w_nside),
        .o_en    (w_en)
    );

    // delay height to line up with the edge-normal path
    always_ff @(posedge i_clk) begin
        r_hdly[0] <= w_height;
        for (int s = 1; s < HDLY; s++) r_hdly[s] <= r_hdly[s-1];
    end

    assign o_valid       = w_nvalid;
    assign o_inside_res  = w_nside.in_tri;
    assign o_failed_edge = w_nside.failed;
    assign o_degenerate  = w_nside.degen;
    assign o_height      = r_hdly[HDLY-1];
    assign o_edge_norm_x = w_en[0];
    assign o_edge_norm_y = w_en[1];
    assign o_edge_norm_z = w_en[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, TOTAL_LAT))
        else $error("result word without a matching accepted word");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_inside_res && (o_height == '0) && (o_failed_edge == EDGE0)))
        else $error("degenerate word carries a height or a failing edge");

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_res) |->
            ((o_edge_norm_x == '0) && (o_edge_norm_y == '0) && (o_edge_norm_z == '0)
             && (o_failed_edge == EDGE0)))
        else $error("inside word carries an edge normal");

    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_failed_edge == EDGE0) || (o_failed_edge == EDGE1)
                     || (o_failed_edge == EDGE2)))
        else $error("failing edge index out of range");

endmodule

/* rtl/core/tpc_front.sv */
// Front stages: differences, plane normal, edge tests, numerator and edge normal cross.
module tpc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tpc_pkg::t_coord  i_vx [3],
    input  tpc_pkg::t_coord  i_vy [3],
    input  tpc_pkg::t_coord  i_vz [3],
    input  tpc_pkg::t_coord  i_qx,
    input  tpc_pkg::t_coord  i_qz,
    output logic             o_valid,
    output tpc_pkg::t_side   o_side,
    output tpc_pkg::t_wide   o_num,
    output tpc_pkg::t_nrm    o_ny,
    output tpc_pkg::t_coord  o_v0y,
    output tpc_pkg::t_wide   o_c [3]
);
    import tpc_pkg::*;

    logic [FRONT_LAT-1:0] r_vld;

    // stage 1
    t_diff  r1_ed [3][3], n1_ed [3][3];
    t_diff  r1_e2 [3], n1_e2 [3];
    t_diff  r1_dx [3], r1_dz [3], n1_dx [3], n1_dz [3];
    t_diff  r1_dqx, r1_dqz;
    t_coord r1_v0y;
    // stage 2
    logic signed [PW-1:0] r2_pn [3][2], n2_pn [3][2];
    logic signed [PW-1:0] r2_pt [3][2], n2_pt [3][2];
    t_diff  r2_ed [3][3];
    t_diff  r2_dqx, r2_dqz;
    t_coord r2_v0y;
    // stage 3
    t_nrm   r3_n [3], n3_n [3];
    t_nrm   r3_t [3], n3_t [3];
    t_diff  r3_ed [3][3];
    t_diff  r3_dqx, r3_dqz;
    t_coord r3_v0y;
    // stage 4
    t_nrm   r4_px [2], r4_pz [2];
    t_nrm   r4_n [3];
    t_diff  r4_es [3], n4_es [3];
    t_side  r4_side, n4_side;
    t_coord r4_v0y;
    logic [2:0] w_fail;
    logic [1:0] w_idx;
    // stage 5
    t_wide  r5_num;
    t_nrm   r5_ph [3][2], r5_pl [3][2], n5_ph [3][2], n5_pl [3][2];
    t_nrm   r5_ny;
    t_side  r5_side;
    t_coord r5_v0y;
    // stage 6
    t_wide  r6_num;
    t_wide  r6_c [3], n6_c [3];
    t_nrm   r6_ny;
    t_side  r6_side;
    t_coord r6_v0y;

    t_coord w_v [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i][0] = i_vx[i];
            w_v[i][1] = i_vy[i];
            w_v[i][2] = i_vz[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_LAT-2:0], i_valid};
        end
    end

    // stage 1: edges, vertex-to-point differences
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n1_ed[i][j] = f_sub(w_v[(i + 1) % 3][j], w_v[i][j]);
            end
            n1_e2[i] = f_sub(w_v[2][i], w_v[0][i]);
            n1_dx[i] = f_sub(i_vx[i], i_qx);
            n1_dz[i] = f_sub(i_vz[i], i_qz);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ed  <= n1_ed;
        r1_e2  <= n1_e2;
        r1_dx  <= n1_dx;
        r1_dz  <= n1_dz;
        r1_dqx <= f_sub(i_qx, i_vx[0]);
        r1_dqz <= f_sub(i_qz, i_vz[0]);
        r1_v0y <= i_vy[0];
    end

    // stage 2: plane normal and edge test products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_pn[k][0] = r1_ed[0][(k + 1) % 3] * r1_e2[(k + 2) % 3];
            n2_pn[k][1] = r1_ed[0][(k + 2) % 3] * r1_e2[(k + 1) % 3];
            n2_pt[k][0] = r1_dz[k] * r1_ed[k][0];
            n2_pt[k][1] = r1_dx[k] * r1_ed[k][2];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pn  <= n2_pn;
        r2_pt  <= n2_pt;
        r2_ed  <= r1_ed;
        r2_dqx <= r1_dqx;
        r2_dqz <= r1_dqz;
        r2_v0y <= r1_v0y;
    end

    // stage 3: differences of products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n3_n[k] = NW'(r2_pn[k][0]) - NW'(r2_pn[k][1]);
            n3_t[k] = NW'(r2_pt[k][0]) - NW'(r2_pt[k][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r3_n   <= n3_n;
        r3_t   <= n3_t;
        r3_ed  <= r2_ed;
        r3_dqx <= r2_dqx;
        r3_dqz <= r2_dqz;
        r3_v0y <= r2_v0y;
    end

    // stage 4: pick first failing edge, split numerator products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_fail[k] = (r3_t[k] != '0) && (r3_t[k][NW-1] != r3_n[1][NW-1]);
        end
        if (w_fail[0]) begin
            w_idx = EDGE0;
        end else if (w_fail[1]) begin
            w_idx = EDGE1;
        end else begin
            w_idx = EDGE2;
        end
        n4_side.degen  = (r3_n[1] == '0);
        n4_side.want   = !n4_side.degen && (w_fail != 3'b000);
        n4_side.in_tri = !n4_side.want;
        n4_side.failed = n4_side.want ? w_idx : EDGE0;
        n4_es = r3_ed[w_idx];
    end

    always_ff @(posedge i_clk) begin
        r4_px[0] <= $signed(r3_n[0][NW-1:SPLIT]) * r3_dqx;
        r4_px[1] <= $signed({1'b0, r3_n[0][SPLIT-1:0]}) * r3_dqx;
        r4_pz[0] <= $signed(r3_n[2][NW-1:SPLIT]) * r3_dqz;
        r4_pz[1] <= $signed({1'b0, r3_n[2][SPLIT-1:0]}) * r3_dqz;
        r4_n     <= r3_n;
        r4_es    <= n4_es;
        r4_side  <= n4_side;
        r4_v0y   <= r3_v0y;
    end

    // stage 5: numerator sum, edge normal partial products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n5_ph[k][0] = r4_es[(k + 1) % 3] * $signed(r4_n[(k + 2) % 3][NW-1:SPLIT]);
            n5_pl[k][0] = r4_es[(k + 1) % 3] * $signed({1'b0, r4_n[(k + 2) % 3][SPLIT-1:0]});
            n5_ph[k][1] = r4_es[(k + 2) % 3] * $signed(r4_n[(k + 1) % 3][NW-1:SPLIT]);
            n5_pl[k][1] = r4_es[(k + 2) % 3] * $signed({1'b0, r4_n[(k + 1) % 3][SPLIT-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        r5_num  <= $signed({r4_px[0], {SPLIT{1'b0}}}) + r4_px[1]
                 + $signed({r4_pz[0], {SPLIT{1'b0}}}) + r4_pz[1];
        r5_ph   <= n5_ph;
        r5_pl   <= n5_pl;
        r5_ny   <= r4_n[1];
        r5_side <= r4_side;
        r5_v0y  <= r4_v0y;
    end

    // stage 6: edge normal = edge x plane normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n6_c[k] = $signed({r5_ph[k][0], {SPLIT{1'b0}}}) + r5_pl[k][0]
                    - $signed({r5_ph[k][1], {SPLIT{1'b0}}}) - r5_pl[k][1];
        end
    end

    always_ff @(posedge i_clk) begin
        r6_num  <= r5_num;
        r6_c    <= n6_c;
        r6_ny   <= r5_ny;
        r6_side <= r5_side;
        r6_v0y  <= r5_v0y;
    end

    assign o_valid = r_vld[FRONT_LAT-1];
    assign o_side  = r6_side;
    assign o_num   = r6_num;
    assign o_ny    = r6_ny;
    assign o_v0y   = r6_v0y;
    assign o_c     = r6_c;

endmodule

/* rtl/core/tpc_height.sv */
// Height on the plane: pipelined restoring divide, rounding and saturation.
module tpc_height (
    input  logic            i_clk,
    input  tpc_pkg::t_wide  i_num,
    input  tpc_pkg::t_nrm   i_ny,
    input  tpc_pkg::t_coord i_v0y,
    input  logic            i_degen,
    output tpc_pkg::t_coord o_height
);
    import tpc_pkg::*;

    localparam int HVW = QB + 2;
    localparam logic signed [HVW-1:0] HMAX = HVW'(2 ** (CW - 1) - 1);
    localparam logic signed [HVW-1:0] HMIN = -HMAX - 1;

    logic [XW-1:0] r1_an;
    logic [NW-1:0] r1_dn;
    logic          r1_qneg, r1_degen;
    t_coord        r1_v0y;

    logic [NW-1:0] r_rem  [QB+1], n_rem [QB+1];
    logic [QB-1:0] r_q    [QB+1], n_q   [QB+1];
    logic [QB-1:0] r_lo   [QB+1];
    logic [NW-1:0] r_dn   [QB+1];
    logic          r_qneg [QB+1], r_ovf [QB+1], r_degen [QB+1];
    t_coord        r_v0y  [QB+1];
    logic [NW:0]   w_rr;
    logic          w_ge;

    logic [QB:0]   r_qr;
    logic          r_rqneg, r_rovf, r_rdegen;
    t_coord        r_rv0y;

    logic signed [HVW-1:0] w_sv, w_hv;
    logic                  w_sat;
    t_coord                n_h, r_h;

    always_ff @(posedge i_clk) begin
        r1_an    <= i_num[XW-1] ? XW'(-i_num) : XW'(i_num);
        r1_dn    <= i_ny[NW-1] ? NW'(-i_ny) : NW'(i_ny);
        r1_qneg  <= i_num[XW-1] ^ i_ny[NW-1];
        r1_degen <= i_degen;
        r1_v0y   <= i_v0y;
    end

    // one quotient bit per stage
    always_comb begin
        n_rem[0] = NW'(r1_an[XW-1:QB]);
        n_q[0]   = '0;
        for (int s = 1; s <= QB; s++) begin
            w_rr     = {r_rem[s-1], r_lo[s-1][QB-s]};
            w_ge     = w_rr >= {1'b0, r_dn[s-1]};
            n_rem[s] = w_ge ? NW'(w_rr - {1'b0, r_dn[s-1]}) : NW'(w_rr);
            n_q[s]   = {r_q[s-1][QB-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]   <= n_rem[0];
        r_q[0]     <= n_q[0];
        r_lo[0]    <= r1_an[QB-1:0];
        r_dn[0]    <= r1_dn;
        r_qneg[0]  <= r1_qneg;
        r_ovf[0]   <= ({{(NW - XW + QB){1'b0}}, r1_an[XW-1:QB]} >= r1_dn);
        r_degen[0] <= r1_degen;
        r_v0y[0]   <= r1_v0y;
        for (int s = 1; s <= QB; s++) begin
            r_rem[s]   <= n_rem[s];
            r_q[s]     <= n_q[s];
            r_lo[s]    <= r_lo[s-1];
            r_dn[s]    <= r_dn[s-1];
            r_qneg[s]  <= r_qneg[s-1];
            r_ovf[s]   <= r_ovf[s-1];
            r_degen[s] <= r_degen[s-1];
            r_v0y[s]   <= r_v0y[s-1];
        end
    end

    // round half away from zero on the magnitude
    always_ff @(posedge i_clk) begin
        r_qr     <= {1'b0, r_q[QB]}
                  + (QB+1)'({r_rem[QB], 1'b0} >= {1'b0, r_dn[QB]});
        r_rqneg  <= r_qneg[QB];
        r_rovf   <= r_ovf[QB];
        r_rdegen <= r_degen[QB];
        r_rv0y   <= r_v0y[QB];
    end

    always_comb begin
        w_sat = r_rovf || (r_qr[QB:QB-1] != 2'b00);
        w_sv  = r_rqneg ? -$signed({1'b0, r_qr}) : $signed({1'b0, r_qr});
        w_hv  = HVW'(r_rv0y) - w_sv;
        if (r_rdegen) begin
            n_h = '0;
        end else if (w_sat) begin
            n_h = r_rqneg ? CW'(HMAX) : CW'(HMIN);
        end else if (w_hv > HMAX) begin
            n_h = CW'(HMAX);
        end else if (w_hv < HMIN) begin
            n_h = CW'(HMIN);
        end else begin
            n_h = CW'(w_hv);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
    end

    assign o_height = r_h;

endmodule

/* rtl/core/tpc_norm.sv */
// Unit edge normal: shift to 30 bits, pipelined square root and dividers.
module tpc_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tpc_pkg::t_side i_side,
    input  tpc_pkg::t_wide i_c [3],
    output logic           o_valid,
    output tpc_pkg::t_side o_side,
    output tpc_pkg::t_en   o_en [3]
);
    import tpc_pkg::*;

    localparam int SQ_ST = 32;
    localparam int SQW   = 2 * SQ_ST;
    localparam int QN    = NFB + 1;
    localparam logic [QN:0] LIM = (QN+1)'(1) << NFB;

    logic [NRM_LAT-1:0] r_vld;
    t_side              r_side [NRM_LAT];
    logic [2:0]         r_sgn  [NRM_LAT];
    logic [2:0]         w_sgn;

    logic [XW-1:0] r1_m [3], r2_m [3], r3_m [3], n2_m [3], n3_m [3];
    logic [XW-1:0] r1_or, r2_or, r3_or, n2_or, n3_or, w_or;
    logic [XW-1:0] w_m [3];
    logic [XW-1:0] n4_m [3];
    logic [NB-1:0] r4_a [3], n4_a [3], r5_a [3], r6_a [3];
    logic [2*NB-1:0] r5_sq [3];
    logic [2*NB+1:0] r6_s;

    logic [SQW-1:0] r_qv [SQ_ST], r_qr [SQ_ST], n_qv [SQ_ST], n_qr [SQ_ST];
    logic [NB-1:0]  r_qa [SQ_ST][3];
    logic [SQW-1:0] w_vin, w_rin, w_bb;

    logic [RW-1:0]  r_dm [QN][3], n_dm [QN][3];
    logic [QN-1:0]  r_dq [QN][3], n_dq [QN][3];
    logic [RW-1:0]  r_dr [QN];
    logic [RW:0]    w_rr;
    logic           w_ge;

    logic [QN:0]    w_qr;
    t_en            r_en [3], n_en [3];

    function automatic logic f_big(input logic [XW-1:0] x, input int k);
        return (x >> (NB - 1 + k)) != '0;
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sgn[k] = i_c[k][XW-1];
        end
    end

    // hold valid, side and signs alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NRM_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_sgn[0]  <= w_sgn;
        for (int s = 1; s < NRM_LAT; s++) begin
            r_side[s] <= r_side[s-1];
            r_sgn[s]  <= r_sgn[s-1];
        end
    end

    // magnitudes
    always_comb begin
        w_or = '0;
        for (int k = 0; k < 3; k++) begin
            w_m[k] = i_c[k][XW-1] ? XW'(-i_c[k]) : XW'(i_c[k]);
            w_or   = w_or | w_m[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m  <= w_m;
        r1_or <= w_or;
    end

    // common right shift, coarse steps first
    always_comb begin
        n2_or = r1_or;
        n2_m  = r1_m;
        if (f_big(n2_or, 64)) begin
            n2_or = n2_or >> 64;
            for (int k = 0; k < 3; k++) n2_m[k] = n2_m[k] >> 64;
        end
        if (f_big(n2_or, 32)) begin
            n2_or = n2_or >> 32;
            for (int k = 0; k < 3; k++) n2_m[k] = n2_m[k] >> 32;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_m  <= n2_m;
        r2_or <= n2_or;
    end

    always_comb begin
        n3_or = r2_or;
        n3_m  = r2_m;
        if (f_big(n3_or, 16)) begin
            n3_or = n3_or >> 16;
            for (int k = 0; k < 3; k++) n3_m[k] = n3_m[k] >> 16;
        end
        if (f_big(n3_or, 8)) begin
            n3_or = n3_or >> 8;
            for (int k = 0; k < 3; k++) n3_m[k] = n3_m[k] >> 8;
        end
        if (f_big(n3_or, 4)) begin
            n3_or = n3_or >> 4;
            for (int k = 0; k < 3; k++) n3_m[k] = n3_m[k] >> 4;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_m  <= n3_m;
        r3_or <= n3_or;
    end

    always_comb begin
        n4_m = r3_m;
        if (f_big(r3_or, 2)) begin
            for (int k = 0; k < 3; k++) n4_m[k] = n4_m[k] >> 2;
            if (f_big(r3_or >> 2, 1)) begin
                for (int k = 0; k < 3; k++) n4_m[k] = n4_m[k] >> 1;
            end
        end else if (f_big(r3_or, 1)) begin
            for (int k = 0; k < 3; k++) n4_m[k] = n4_m[k] >> 1;
        end
        for (int k = 0; k < 3; k++) n4_a[k] = n4_m[k][NB-1:0];
    end

    always_ff @(posedge i_clk) begin
        r4_a <= n4_a;
        for (int k = 0; k < 3; k++) r5_sq[k] <= r4_a[k] * r4_a[k];
        r5_a <= r4_a;
        r6_s <= (2*NB+2)'(r5_sq[0]) + (2*NB+2)'(r5_sq[1]) + (2*NB+2)'(r5_sq[2]);
        r6_a <= r5_a;
    end

    // floor square root, one result bit per stage
    always_comb begin
        for (int i = 0; i < SQ_ST; i++) begin
            if (i == 0) begin
                w_vin = SQW'(r6_s);
                w_rin = '0;
            end else begin
                w_vin = r_qv[i-1];
                w_rin = r_qr[i-1];
            end
            w_bb = SQW'(1) << (2 * (SQ_ST - 1 - i));
            if (w_vin >= w_rin + w_bb) begin
                n_qv[i] = w_vin - (w_rin + w_bb);
                n_qr[i] = (w_rin >> 1) + w_bb;
            end else begin
                n_qv[i] = w_vin;
                n_qr[i] = w_rin >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_qv    <= n_qv;
        r_qr    <= n_qr;
        r_qa[0] <= r6_a;
        for (int i = 1; i < SQ_ST; i++) r_qa[i] <= r_qa[i-1];
    end

    // (a << NFB) / root, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < QN; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (j == 0) begin
                    w_rr    = (RW+1)'(r_qa[SQ_ST-1][k]);
                    w_ge    = w_rr >= {1'b0, r_qr[SQ_ST-1][RW-1:0]};
                    n_dm[j][k] = w_ge ? RW'(w_rr - {1'b0, r_qr[SQ_ST-1][RW-1:0]})
                                      : RW'(w_rr);
                    n_dq[j][k] = QN'(w_ge);
                end else begin
                    w_rr    = {r_dm[j-1][k], 1'b0};
                    w_ge    = w_rr >= {1'b0, r_dr[j-1]};
                    n_dm[j][k] = w_ge ? RW'(w_rr - {1'b0, r_dr[j-1]}) : RW'(w_rr);
                    n_dq[j][k] = {r_dq[j-1][k][QN-2:0], w_ge};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dm    <= n_dm;
        r_dq    <= n_dq;
        r_dr[0] <= r_qr[SQ_ST-1][RW-1:0];
        for (int j = 1; j < QN; j++) r_dr[j] <= r_dr[j-1];
    end

    // round, clamp, restore sign; zero for a pass or a null normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_qr = {1'b0, r_dq[QN-1][k]}
                 + (QN+1)'({r_dm[QN-1][k], 1'b0} >= {1'b0, r_dr[QN-1]});
            if (w_qr > LIM) w_qr = LIM;
            if (!r_side[NRM_LAT-2].want || (r_dr[QN-1] == '0)) begin
                n_en[k] = '0;
            end else if (r_sgn[NRM_LAT-2][k]) begin
                n_en[k] = ENW'(-$signed({1'b0, w_qr}));
            end else begin
                n_en[k] = ENW'(w_qr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_en <= n_en;
    end

    assign o_valid = r_vld[NRM_LAT-1];
    assign o_side  = r_side[NRM_LAT-1];
    assign o_en    = r_en;

endmodule

/* sim/testbench.sv */
// Self-checking bench for the triangle point containment pipeline.
module testbench;
    import tpc_pkg::*;

    typedef logic signed [127:0] t_big;

    // One expected result word.
    typedef struct packed {
        logic       in_tri;
        logic [1:0] failed;
        t_coord     height;
        t_en        nx;
        t_en        ny;
        t_en        nz;
        logic       degen;
    } t_hit;

    // One directed stimulus row: 11 coordinates, and a typed answer where obvious.
    typedef struct {
        t_coord crd[11];
        bit     typed;
        t_hit   answer;
    } t_row;

    localparam int WATCHDOG_LIMIT = 4 * (TOTAL_LAT + 20) + 200;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord crd[11];
    logic   o_valid;
    logic   o_inside_res;
    logic [1:0] o_failed_edge;
    t_coord o_height;
    t_en    o_edge_norm_x;
    t_en    o_edge_norm_y;
    t_en    o_edge_norm_z;
    logic   o_degenerate;

    t_hit   pending_hits[$];
    t_row   directed_rows[$];
    int     fail_count = 0;
    int     idle_cycles = 0;

    triangle_point_containment_test_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_v0_x        (crd[0]),
        .i_v0_y        (crd[1]),
        .i_v0_z        (crd[2]),
        .i_v1_x        (crd[3]),
        .i_v1_y        (crd[4]),
        .i_v1_z        (crd[5]),
        .i_v2_x        (crd[6]),
        .i_v2_y        (crd[7]),
        .i_v2_z        (crd[8]),
        .i_query_x     (crd[9]),
        .i_query_z     (crd[10]),
        .o_valid       (o_valid),
        .o_inside_res  (o_inside_res),
        .o_failed_edge (o_failed_edge),
        .o_height      (o_height),
        .o_edge_norm_x (o_edge_norm_x),
        .o_edge_norm_y (o_edge_norm_y),
        .o_edge_norm_z (o_edge_norm_z),
        .o_degenerate  (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int bit_length(input t_big mag);
        int len;
        len = 0;
        for (int b = 0; b < 128; b++) begin
            if (mag[b]) len = b + 1;
        end
        return len;
    endfunction

    function automatic t_big magnitude(input t_big v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int sign_of(input t_big v);
        return v == 0 ? 0 : (v < 0 ? -1 : 1);
    endfunction

    // Floor square root of a 64-bit value, digit by digit.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale an exact edge normal to unit length in Q1.14.
    function automatic void unit_edge_normal(input t_big c[3], output t_en o[3]);
        logic [63:0] part[3];
        logic [63:0] sum_sq, root, m, q;
        int len, sh;
        len = 0;
        sum_sq = 0;
        for (int i = 0; i < 3; i++) begin
            if (bit_length(magnitude(c[i])) > len) len = bit_length(magnitude(c[i]));
        end
        sh = len > NB ? len - NB : 0;
        for (int i = 0; i < 3; i++) begin
            part[i] = 64'(magnitude(c[i]) >> sh) & ((64'd1 << NB) - 1);
            sum_sq += part[i] * part[i];
        end
        root = floor_root(sum_sq);
        for (int i = 0; i < 3; i++) begin
            if (root == 0) begin
                o[i] = '0;
            end else begin
                m = part[i] << NFB;
                q = m / root;
                if (2 * (m % root) >= root) q++;
                if (q > (64'd1 << NFB)) q = 64'd1 << NFB;
                o[i] = c[i] < 0 ? t_en'(-q) : t_en'(q);
            end
        end
    endfunction

    function automatic void cross3(input t_big a[3], input t_big b[3], output t_big o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Work out the containment result for one triangle and query point.
    function automatic t_hit containment_of(input t_coord c[11]);
        t_big vtx[3][3];
        t_big e1[3], e2[3], pn[3], edge_v[3], en_exact[3];
        t_big num, quo, rem, qx, qz, ex, ez, dx, dz, t;
        t_big hgt;
        t_en  en[3];
        t_hit h;
        int   nys, nxt;
        logic qneg;
        h = '{in_tri: 1'b1, failed: EDGE0, height: '0, nx: '0, ny: '0, nz: '0, degen: 1'b0};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) vtx[i][j] = t_big'(c[i * 3 + j]);
        qx = t_big'(c[9]);
        qz = t_big'(c[10]);
        for (int j = 0; j < 3; j++) begin
            e1[j] = vtx[1][j] - vtx[0][j];
            e2[j] = vtx[2][j] - vtx[0][j];
        end
        cross3(e1, e2, pn);
        nys = sign_of(pn[1]);
        if (nys == 0) begin
            h.degen = 1'b1;
            return h;
        end
        num = pn[0] * (qx - vtx[0][0]) + pn[2] * (qz - vtx[0][2]);
        quo = magnitude(num) / magnitude(pn[1]);
        rem = magnitude(num) % magnitude(pn[1]);
        if (2 * rem >= magnitude(pn[1])) quo++;
        qneg = (num < 0) ^ (pn[1] < 0);
        if (bit_length(quo) > 34) begin
            h.height = qneg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end else begin
            hgt = vtx[0][1] - (qneg ? -quo : quo);
            if (hgt > 32'sh7FFF_FFFF) hgt = 32'sh7FFF_FFFF;
            if (hgt < -t_big'(64'sh8000_0000)) hgt = -t_big'(64'sh8000_0000);
            h.height = t_coord'(hgt);
        end
        // Walk the edges in order; stop at the first one the point lies beyond.
        for (int i = 0; i < 3 && h.in_tri; i++) begin
            nxt = (i + 1) % 3;
            ex = vtx[nxt][0] - vtx[i][0];
            ez = vtx[nxt][2] - vtx[i][2];
            dx = vtx[i][0] - qx;
            dz = vtx[i][2] - qz;
            t  = dz * ex - dx * ez;
            if (sign_of(t) != 0 && sign_of(t) != nys) begin
                for (int j = 0; j < 3; j++) edge_v[j] = vtx[nxt][j] - vtx[i][j];
                cross3(edge_v, pn, en_exact);
                unit_edge_normal(en_exact, en);
                h.in_tri = 1'b0;
                h.failed = 2'(i);
                h.nx = en[0];
                h.ny = en[1];
                h.nz = en[2];
            end
        end
        return h;
    endfunction

    task automatic add_row(input t_coord c[11], input bit typed, input t_hit answer);
        t_row r;
        r.crd    = c;
        r.typed  = typed;
        r.answer = answer;
        directed_rows.push_back(r);
    endtask

    // Wait a random gap, hold the word, raise start and await the accepting edge.
    task automatic send_word(input t_coord c[11], input t_hit want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int k = 0; k < 11; k++) crd[k] <= c[k];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_hits.push_back(want);
    endtask

    function automatic t_coord spread(input int sh);
        return t_coord'($signed($urandom) >>> sh);
    endfunction

    // Build a random triangle: mostly well-placed ones with the query near them.
    function automatic void random_triangle(output t_coord c[11]);
        int mode, sh;
        t_coord ctr_x, ctr_y, ctr_z;
        longint sx, sz;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            for (int k = 0; k < 11; k++) c[k] = t_coord'($urandom);
            return;
        end
        sh = $urandom_range(2, 28);
        ctr_x = spread(sh - 1);
        ctr_y = spread($urandom_range(1, 31));
        ctr_z = spread(sh - 1);
        for (int i = 0; i < 3; i++) begin
            c[i * 3]     = ctr_x + spread(sh);
            c[i * 3 + 1] = ctr_y + spread($urandom_range(sh, 31));
            c[i * 3 + 2] = ctr_z + spread(sh);
        end
        if (mode == 1) begin
            // Collinear in the x-z plane: no plane height exists.
            c[6] = c[0] + 2 * (c[3] - c[0]);
            c[8] = c[2] + 2 * (c[5] - c[2]);
        end else if (mode == 2) begin
            c[3] = c[0];
            c[5] = c[2];
        end
        if (mode >= 6) begin
            sx = (longint'(c[0]) + c[3] + c[6]) / 3;
            sz = (longint'(c[2]) + c[5] + c[8]) / 3;
            c[9]  = t_coord'(sx) + spread(sh + 2);
            c[10] = t_coord'(sz) + spread(sh + 2);
        end else if (mode == 5) begin
            c[9]  = c[$urandom_range(0, 2) * 3];
            c[10] = c[$urandom_range(0, 2) * 3 + 2];
        end else begin
            c[9]  = ctr_x + spread(sh - 1);
            c[10] = ctr_z + spread(sh - 1);
        end
    endfunction

    // Watchdog and result checker; both look at values settled before the edge.
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_hits.size() == 0) begin
                $error("result word with no word pending");
                fail_count++;
            end else begin
                want = pending_hits.pop_front();
                if (o_inside_res !== want.in_tri) begin
                    $error("inside_res: expected %0d, got %0d", want.in_tri, o_inside_res);
                    fail_count++;
                end
                if (o_failed_edge !== want.failed) begin
                    $error("failed_edge: expected %0d, got %0d", want.failed, o_failed_edge);
                    fail_count++;
                end
                if (o_height !== want.height) begin
                    $error("height: expected %0d, got %0d", want.height, o_height);
                    fail_count++;
                end
                if (o_edge_norm_x !== want.nx) begin
                    $error("edge_norm_x: expected %0d, got %0d", want.nx, o_edge_norm_x);
                    fail_count++;
                end
                if (o_edge_norm_y !== want.ny) begin
                    $error("edge_norm_y: expected %0d, got %0d", want.ny, o_edge_norm_y);
                    fail_count++;
                end
                if (o_edge_norm_z !== want.nz) begin
                    $error("edge_norm_z: expected %0d, got %0d", want.nz, o_edge_norm_z);
                    fail_count++;
                end
                if (o_degenerate !== want.degen) begin
                    $error("degenerate: expected %0d, got %0d", want.degen, o_degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_coord c[11];
        t_hit   flat;
        t_row   r;
        localparam t_coord MX = 32'sh7FFF_FFFF;
        localparam t_coord MN = 32'sh8000_0000;
        localparam t_coord ONE = 32'sh0001_0000;
        i_rst_n = 1'b0;
        start   = 1'b0;
        for (int k = 0; k < 11; k++) crd[k] = '0;
        flat = '{in_tri: 1'b1, failed: EDGE0, height: '0, nx: '0, ny: '0, nz: '0, degen: 1'b1};

        // Directed rows: degenerate planes get a typed answer, the rest the predictor.
        add_row('{11{t_coord'(0)}}, 1, flat);
        add_row('{11{MX}}, 1, flat);
        add_row('{11{MN}}, 1, flat);
        add_row('{MN, MX, MN, MX, MN, MX, MN, MX, MN, MX, MN}, 1, flat);
        add_row('{0, 0, 0, ONE, 0, ONE, 2 * ONE, 0, 2 * ONE, 0, 0}, 1, flat);
        add_row('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE / 4, ONE / 4}, 0, flat);
        add_row('{0, 0, 0, 0, 0, ONE, ONE, 0, 0, ONE / 4, ONE / 4}, 0, flat);
        add_row('{0, ONE, 0, ONE, 3 * ONE, 0, 0, -ONE, ONE, ONE / 3, ONE / 3}, 0, flat);
        add_row('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE / 2, -ONE}, 0, flat);
        add_row('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, 2 * ONE, ONE / 4}, 0, flat);
        add_row('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, -ONE, ONE / 4}, 0, flat);
        add_row('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE / 2, 0}, 0, flat);
        add_row('{0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, 0}, 0, flat);
        add_row('{0, 0, 0, 1, MX, 0, 0, 0, 1, MX, MX}, 0, flat);
        add_row('{0, 0, 0, 1, MN, 0, 0, 0, 1, MX, MN}, 0, flat);
        add_row('{MN, MN, MN, MX, MX, MN, MN, MX, MX, MX, MX}, 0, flat);
        add_row('{MX, MX, MX, MN, MN, MX, MX, MN, MN, MN, MN}, 0, flat);
        add_row('{MN, 0, MN, MX, 0, MN, MN, 0, MX, 0, 0}, 0, flat);
        add_row('{MX, 0, MX, MN, MX, MX, MX, MN, MN, MX, MN}, 0, flat);
        add_row('{0, 0, 0, 0, MX, 1, 1, MN, 0, MN, MN}, 0, flat);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            r = directed_rows[n];
            send_word(r.crd, r.typed ? r.answer : containment_of(r.crd));
        end
        repeat (1900) begin
            random_triangle(c);
            send_word(c, containment_of(c));
        end
        start <= 1'b0;

        // Drain the pipeline, then allow its latency once more for strays.
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
        if (fail_count == 0 && pending_hits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/tpc_pkg.sv
rtl/core/tpc_front.sv
rtl/core/tpc_height.sv
rtl/core/tpc_norm.sv
rtl/core/triangle_point_containment_test_unit.sv
sim/testbench.sv
